>>> design/xdrh_pkg.sv
// Shared types and constants for the XOR delta rewind history unit.
package xdrh_pkg;

  localparam int MAX_FRAME_WORDS = 4096;
  localparam int PAIR_DEPTH      = 65536;
  localparam int MAX_HISTORY     = 1024;

  typedef enum logic [2:0] {
    MODE_WRITE  = 3'd0,
    MODE_SUBMIT = 3'd1,
    MODE_REWIND = 3'd2,
    MODE_READ   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  localparam logic REG_FRAME_WORDS = 1'b0;
  localparam logic REG_MAX_FRAMES  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CMP_RD,
    ST_CMP,
    ST_TRIM,
    ST_TRIM_RD,
    ST_STORE,
    ST_POST_RD,
    ST_POST,
    ST_POST_DROP,
    ST_RW_CNT_RD,
    ST_RW_CNT,
    ST_RW_PAIR_RD,
    ST_RW_WORD_RD,
    ST_RW_WORD_WR,
    ST_DONE
  } state_t;

endpackage

>>> design/xor_delta_rewind_history_unit.sv
// Top level of the XOR delta rewind history unit: frame banks, pair ring and sequencer.
// A transaction starts when start is high and busy is low; one result follows, marked by
// done for a single cycle, and the receiver cannot stall it. Submit walks the frame twice
// through the bank read port and drops the oldest deltas as needed to make room; rewind
// undoes deltas pair by pair, as each memory has a single port. After reset the banks
// are cleared one word a cycle, during which busy is high.
module xor_delta_rewind_history_unit
  import xdrh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [11:0] word_index,
  input  logic [31:0] word_data,
  input  logic [10:0] rewind_count,
  output logic        done,
  output logic [31:0] read_data,
  output logic [10:0] frames_available,
  output logic [10:0] frames_rewound,
  output logic [16:0] pairs_stored,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int WA = $clog2(MAX_FRAME_WORDS);
  localparam int PA = $clog2(PAIR_DEPTH);
  localparam int HA = $clog2(MAX_HISTORY);
  localparam int FW = WA + 1;
  localparam int PW = PA + 1;
  localparam int HW = HA + 1;

  // Memories: two frame banks, the pair ring and the per-delta pair counts.
  logic [31:0]   bank_a [MAX_FRAME_WORDS];
  logic [31:0]   bank_b [MAX_FRAME_WORDS];
  logic [WA-1:0] pos_mem [PAIR_DEPTH];
  logic [31:0]   dlt_mem [PAIR_DEPTH];
  logic [PW-1:0] cnt_mem [MAX_HISTORY];

  state_t state, state_next;

  logic [12:0]   frame_words;
  logic [10:0]   max_frames;
  logic          cur_b;
  logic [PA-1:0] p_head;
  logic [PW-1:0] p_fill;
  logic [HA-1:0] h_head;
  logic [HW-1:0] h_count;

  logic [2:0]    op;
  logic [11:0]   op_idx;
  logic [10:0]   op_cnt;
  logic [FW-1:0] fw_eff;
  logic [HW-1:0] mf_eff;
  logic [FW-1:0] walk;
  logic [PW-1:0] diffs;
  logic [PW-1:0] n_left;
  logic [10:0]   rew;
  logic          st_flag;
  logic [31:0]   rd_hold;
  logic [WA-1:0] wpos;
  logic [31:0]   wdlt;
  logic          big;

  // Bank ports, pair and count ports.
  logic          a_we, b_we;
  logic [WA-1:0] a_addr, b_addr;
  logic [31:0]   a_wd, b_wd, a_rd, b_rd;
  logic          p_we;
  logic [PA-1:0] p_addr;
  logic [WA-1:0] p_wpos;
  logic [31:0]   p_wdlt, p_rdlt;
  logic [WA-1:0] p_rpos;
  logic          c_we;
  logic [HA-1:0] c_addr;
  logic [PW-1:0] c_wd, c_rd;

  always_ff @(posedge clk) begin
    if (a_we) bank_a[a_addr] <= a_wd;
    a_rd <= bank_a[a_addr];
  end
  always_ff @(posedge clk) begin
    if (b_we) bank_b[b_addr] <= b_wd;
    b_rd <= bank_b[b_addr];
  end
  always_ff @(posedge clk) begin
    if (p_we) begin
      pos_mem[p_addr] <= p_wpos;
      dlt_mem[p_addr] <= p_wdlt;
    end
    p_rpos <= pos_mem[p_addr];
    p_rdlt <= dlt_mem[p_addr];
  end
  always_ff @(posedge clk) begin
    if (c_we) cnt_mem[c_addr] <= c_wd;
    c_rd <= cnt_mem[c_addr];
  end

  logic [31:0] cur_rd, nxt_rd;
  assign cur_rd = cur_b ? b_rd : a_rd;
  assign nxt_rd = cur_b ? a_rd : b_rd;

  logic [PW:0]   fill_plus;
  logic [PA-1:0] tail_ptr;
  logic [PA-1:0] last_ptr;
  logic [HA-1:0] new_slot;
  logic [HA-1:0] top_slot;
  logic [PW-1:0] drop_n;
  logic          walk_end;
  logic          ring_over;
  logic          can_drop;
  assign fill_plus = {1'b0, p_fill} + {1'b0, diffs};
  assign tail_ptr  = p_head + p_fill[PA-1:0];
  assign last_ptr  = tail_ptr - PA'(1);
  assign new_slot  = h_head + h_count[HA-1:0];
  assign top_slot  = new_slot - HA'(1);
  assign drop_n    = (c_rd > p_fill) ? p_fill : c_rd;
  assign walk_end  = (walk == fw_eff);
  assign ring_over = fill_plus > (PW+1)'(PAIR_DEPTH);
  assign can_drop  = h_count != '0;

  logic in_accept;
  assign busy      = (state != ST_IDLE);
  assign in_accept = start && !busy;
  assign cfg_ready = 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (mode)
            MODE_SUBMIT: state_next = ST_CMP_RD;
            MODE_REWIND: state_next = ST_RW_CNT_RD;
            MODE_READ:   state_next = ST_RW_WORD_RD;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_INIT:    if (walk == FW'(MAX_FRAME_WORDS - 1)) state_next = ST_IDLE;
      ST_CMP_RD:  state_next = walk_end ? ST_TRIM_RD : ST_CMP;
      ST_CMP:     state_next = walk_end ? ST_TRIM_RD : ST_CMP;
      ST_TRIM_RD: state_next = ST_TRIM;
      ST_TRIM: begin
        if (big) state_next = ST_POST_RD;
        else if (can_drop && (h_count == HW'(MAX_HISTORY) || ring_over))
          state_next = ST_TRIM_RD;
        else state_next = ST_STORE;
      end
      ST_STORE:      if (walk_end) state_next = ST_POST_RD;
      ST_POST_RD:    state_next = ST_POST;
      ST_POST:       state_next = ST_POST_DROP;
      ST_POST_DROP:  state_next = ST_DONE;
      ST_RW_CNT_RD:  state_next = ST_RW_CNT;
      ST_RW_CNT: begin
        if (rew == op_cnt || !can_drop) state_next = ST_DONE;
        else if (drop_n == '0) state_next = ST_RW_CNT_RD;
        else state_next = ST_RW_PAIR_RD;
      end
      ST_RW_PAIR_RD: state_next = ST_RW_WORD_RD;
      ST_RW_WORD_RD: state_next = (op == MODE_READ) ? ST_DONE : ST_RW_WORD_WR;
      ST_RW_WORD_WR: state_next = (n_left == PW'(1)) ? ST_RW_CNT_RD : ST_RW_PAIR_RD;
      ST_DONE:       state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    a_we = 1'b0; b_we = 1'b0;
    a_addr = walk[WA-1:0]; b_addr = walk[WA-1:0];
    a_wd = '0; b_wd = '0;
    p_we = 1'b0; p_addr = last_ptr;
    p_wpos = walk[WA-1:0] - WA'(1); p_wdlt = cur_rd ^ nxt_rd;
    c_we = 1'b0; c_addr = h_head; c_wd = diffs;
    case (state)
      ST_INIT: begin
        a_we = 1'b1; b_we = 1'b1;
      end
      ST_IDLE: begin
        if (in_accept && mode == MODE_WRITE && 32'(word_index) < 32'(MAX_FRAME_WORDS)) begin
          a_addr = word_index[WA-1:0]; b_addr = word_index[WA-1:0];
          a_wd = word_data; b_wd = word_data;
          a_we = cur_b; b_we = !cur_b;
        end
      end
      ST_STORE: begin
        p_addr = tail_ptr;
        p_we = (walk != '0) && ((cur_rd ^ nxt_rd) != '0);
      end
      ST_POST_RD: begin
        c_addr = new_slot;
        c_we = !big;
      end
      ST_POST: c_addr = h_head;
      ST_RW_CNT_RD: c_addr = top_slot;
      // The newest remaining pair always sits just below the tail.
      ST_RW_PAIR_RD: p_addr = last_ptr;
      ST_RW_WORD_RD: begin
        a_addr = (op == MODE_READ) ? op_idx[WA-1:0] : p_rpos;
        b_addr = a_addr;
      end
      ST_RW_WORD_WR: begin
        a_addr = wpos; b_addr = wpos;
        a_wd = a_rd ^ wdlt; b_wd = b_rd ^ wdlt;
        a_we = !cur_b; b_we = cur_b;
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      walk <= '0;
      frame_words <= 13'd4096;
      max_frames <= 11'd1024;
      cur_b <= 1'b0;
      p_head <= '0; p_fill <= '0;
      h_head <= '0; h_count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WORDS) frame_words <= cfg_data[12:0];
        if (cfg_index == REG_MAX_FRAMES) max_frames <= cfg_data[10:0];
      end
      case (state)
        ST_INIT: walk <= walk + FW'(1);
        ST_IDLE: begin
          if (in_accept) begin
            op <= mode; op_idx <= word_index; op_cnt <= rewind_count;
            fw_eff <= (32'(frame_words) > 32'(MAX_FRAME_WORDS)) ? FW'(MAX_FRAME_WORDS)
                                                                : FW'(frame_words);
            mf_eff <= (32'(max_frames) > 32'(MAX_HISTORY)) ? HW'(MAX_HISTORY)
                                                           : HW'(max_frames);
            walk <= '0; diffs <= '0; rew <= '0; st_flag <= 1'b0; rd_hold <= '0;
            big <= 1'b0;
            if (mode == MODE_CLEAR) begin
              p_head <= '0; p_fill <= '0; h_head <= '0; h_count <= '0;
            end
          end
        end
        ST_CMP_RD: walk <= walk_end ? '0 : walk + FW'(1);
        ST_CMP: begin
          if ((cur_rd ^ nxt_rd) != '0) diffs <= diffs + PW'(1);
          walk <= walk_end ? '0 : walk + FW'(1);
          if (walk_end) big <= 1'b0;
        end
        ST_TRIM_RD: begin
          if ({1'b0, diffs} > (PW+1)'(PAIR_DEPTH)) big <= 1'b1;
        end
        ST_TRIM: begin
          if (big) begin
            p_head <= '0; p_fill <= '0; h_head <= '0; h_count <= '0; st_flag <= 1'b1;
          end else if (can_drop && (h_count == HW'(MAX_HISTORY) || ring_over)) begin
            p_head <= p_head + drop_n[PA-1:0];
            p_fill <= p_fill - drop_n;
            h_head <= h_head + HA'(1);
            h_count <= h_count - HW'(1);
            if (h_count != HW'(MAX_HISTORY)) st_flag <= 1'b1;
          end
        end
        ST_STORE: begin
          if (p_we) p_fill <= p_fill + PW'(1);
          walk <= walk + FW'(1);
        end
        ST_POST_RD: begin
          cur_b <= !cur_b;
          if (!big) h_count <= h_count + HW'(1);
        end
        ST_POST_DROP: begin
          if ({1'b0, h_count} + (HW+1)'(1) > {1'b0, mf_eff} && can_drop) begin
            p_head <= p_head + drop_n[PA-1:0];
            p_fill <= p_fill - drop_n;
            h_head <= h_head + HA'(1);
            h_count <= h_count - HW'(1);
          end
        end
        ST_RW_CNT: begin
          // A delta with no pairs still counts as one undone frame.
          if (rew != op_cnt && can_drop) begin
            if (drop_n == '0) begin
              rew <= rew + 11'd1;
              h_count <= h_count - HW'(1);
            end else begin
              n_left <= drop_n;
            end
          end
        end
        ST_RW_WORD_RD: begin
          wpos <= p_rpos; wdlt <= p_rdlt;
        end
        ST_RW_WORD_WR: begin
          p_fill <= p_fill - PW'(1);
          n_left <= n_left - PW'(1);
          if (n_left == PW'(1)) begin
            rew <= rew + 11'd1;
            h_count <= h_count - HW'(1);
          end
        end
        ST_DONE: begin
          if (op == MODE_READ && 32'(op_idx) < 32'(MAX_FRAME_WORDS)) rd_hold <= cur_rd;
        end
        default: ;
      endcase
    end
  end

  logic [31:0] out_rd;
  assign out_rd = (op == MODE_READ && 32'(op_idx) < 32'(MAX_FRAME_WORDS)) ? rd_hold : '0;

  always_comb begin
    read_data        = out_rd;
    frames_available = 11'(h_count);
    frames_rewound   = (op == MODE_REWIND) ? rew : '0;
    pairs_stored     = (op == MODE_SUBMIT) ? 17'(diffs) : '0;
    status           = (op == MODE_SUBMIT) && st_flag;
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !$past(done))
    else $error("done held for two cycles");
  assert property (@(posedge clk) disable iff (rst) in_accept |=> busy)
    else $error("busy not raised after accept");
  assert property (@(posedge clk) disable iff (rst) h_count <= HW'(MAX_HISTORY))
    else $error("history count overflow");
  assert property (@(posedge clk) disable iff (rst) p_fill <= PW'(PAIR_DEPTH))
    else $error("pair fill overflow");

endmodule
